// ===== rtl/core/matrix_multiply_engine_top_macros.svh =====
// Assertion macros shared by the matrix multiply engine RTL.
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mme_pkg.sv =====
// Shared types, codes and defaults of the matrix multiply engine.
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    localparam int DEF_MAX_DIM    = 32;
    localparam int DEF_ELEM_WIDTH = 16;

    localparam int FIELD_ELEM_W = 16;   // width of the value field
    localparam int IDX_W        = 5;    // width of row and column fields
    localparam int DIM_W        = 6;    // width of a dimension register
    localparam int CFG_IDX_W    = 2;
    localparam int PROD_W       = 32;

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DRAIN,
        ST_BAD
    } t_state;

    // Control that travels with one A element along the cell chain.
    typedef struct packed {
        logic v;
        logic first;
        logic last;
        logic zero;
    } t_beat_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/mme_cell.sv =====
// One multiply-accumulate cell of the chain: holds one column of B.
`timescale 1ns / 1ps
`default_nettype none

module mme_cell #(
    parameter int EW    = 16,
    parameter int IW    = 5,
    parameter int ACC_W = 38,
    parameter int COL   = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire logic signed [EW-1:0]    i_a,
    input  wire logic [IW-1:0]           i_k,
    input  wire mme_pkg::t_beat_ctl      i_ctl,
    output logic signed [EW-1:0]         o_a,
    output logic [IW-1:0]                o_k,
    output mme_pkg::t_beat_ctl           o_ctl,
    input  wire logic                    i_wen,
    input  wire logic [IW-1:0]           i_wcol,
    input  wire logic [IW-1:0]           i_waddr,
    input  wire logic signed [EW-1:0]    i_wdata,
    input  wire logic                    i_shift,
    input  wire logic signed [ACC_W-1:0] i_res,
    output logic signed [ACC_W-1:0]      o_res,
    output logic                         o_done
);
    import mme_pkg::*;

    logic signed [EW-1:0]    b_mem [0:(1 << IW)-1];

    logic signed [EW-1:0]    r_a;
    logic signed [EW-1:0]    r_b;
    logic [IW-1:0]           r_k;
    t_beat_ctl               r_ctl;
    logic signed [2*EW-1:0]  r_prod;
    t_beat_ctl               r_pctl;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_res;
    logic                    r_done;

    logic                    w_we;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_sum;

    assign w_we   = i_wen && (i_wcol == IW'(COL));
    assign w_base = r_pctl.first ? '0 : r_acc;
    assign w_sum  = w_base + ACC_W'(r_prod);

    // Column store, B read at incoming k, multiply and accumulate.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            b_mem[i_waddr] <= i_wdata;
        end
        r_b <= b_mem[i_k];
        r_a <= i_a;
        r_k <= i_k;
        if (r_ctl.zero) begin
            r_prod <= '0;
        end else begin
            r_prod <= (2*EW)'(r_a) * (2*EW)'(r_b);
        end
        if (r_pctl.v) begin
            r_acc <= w_sum;
        end
        if (r_pctl.v && r_pctl.last) begin
            r_res <= w_sum;
        end else if (i_shift) begin
            r_res <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_pctl <= r_ctl;
            r_done <= r_pctl.v && r_pctl.last;
        end
    end

    assign o_a    = r_a;
    assign o_k    = r_k;
    assign o_ctl  = r_ctl;
    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/matrix_multiply_engine_top.sv =====
// Top level of the matrix multiply engine: stores, sequencer, cell chain, output.
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_multiply_engine_top_macros.svh"

// Matrix multiply engine. A (rows_a x inner_dim) lives in one memory of the
// top level; B is split by column over a chain of min(MAX_DIM, 32) cells, each
// holding one column in a small memory of its own. A load transfer (mode 0 or 1)
// gives no result; a load outside the configured dimensions is dropped. A
// compute transfer (mode 2) streams row i of A, one element per
// cycle, into the first cell, and each cell hands the element to its neighbor
// while it multiplies it with its own B entry and accumulates at full
// precision. When the last cell has its sum, the sums shift down the chain to
// the output, one per cycle while the output register is free, rounded half
// up to Q16.16 and saturated to 32 bits, in column order with last set on
// column cols_b-1. A good row occupies the block while its row streams and
// the chain fills, then while its cols_b results go out (longer if the sink
// stalls); the A memory read port and the chain length set the fill. A row
// not below rows_a gives one result with bad_row and last set. Only one
// item is in flight; the input is ready again once the last result sits in the
// output register. Registers are written through the configuration channel
// (index 0 rows_a, 1 inner_dim, 2 cols_b; other indices are dropped), which is
// always ready; dimensions above min(MAX_DIM, 32) act as that limit. Entries
// of A and B that were never written read as unknown values.
module matrix_multiply_engine_top #(
    parameter int MAX_DIM    = mme_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = mme_pkg::DEF_ELEM_WIDTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mme_pkg::DIM_W-1:0]       i_cfg_data,
    // Input channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [mme_pkg::IDX_W-1:0]       i_row,
    input  wire logic [mme_pkg::IDX_W-1:0]       i_col,
    input  wire logic signed [mme_pkg::FIELD_ELEM_W-1:0] i_value,
    // Output channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [mme_pkg::IDX_W-1:0]            o_out_row,
    output logic [mme_pkg::IDX_W-1:0]            o_out_col,
    output logic signed [mme_pkg::PROD_W-1:0]    o_product,
    output logic                                 o_last,
    output logic                                 o_bad_row
);
    import mme_pkg::*;

    // Chain length is capped by the reach of the 5-bit indices.
    localparam int LIM     = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);
    localparam int EW      = (ELEM_WIDTH < FIELD_ELEM_W) ? ELEM_WIDTH : FIELD_ELEM_W;
    localparam int IW      = $clog2(LIM);
    localparam int ACC_W   = 2*EW + IW + 1;
    localparam int A_DEPTH = 1 << (2*IW);
    localparam logic [DIM_W-1:0] LIM_D   = DIM_W'(LIM);
    localparam logic [DIM_W-1:0] RESET_D = DIM_W'(32);

    // Configuration registers
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner_dim;
    logic [DIM_W-1:0] r_cols_b;

    // Sequencer
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] n_row;
    logic [IW-1:0]    r_k;
    logic [IW-1:0]    n_k;
    logic [IW-1:0]    r_j;
    logic [IW-1:0]    n_j;

    // A store and the beat that enters the first cell
    logic signed [EW-1:0] a_mem [0:A_DEPTH-1];
    logic signed [EW-1:0] r_a_rd;
    logic [IW-1:0]        r_beat_k;
    t_beat_ctl            r_beat_ctl;
    t_beat_ctl            n_beat_ctl;

    // Output register
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic [IDX_W-1:0]          r_out_row;
    logic [IDX_W-1:0]          n_out_row;
    logic [IDX_W-1:0]          r_out_col;
    logic [IDX_W-1:0]          n_out_col;
    logic signed [PROD_W-1:0]  r_out_prod;
    logic signed [PROD_W-1:0]  n_out_prod;
    logic                      r_out_last;
    logic                      n_out_last;
    logic                      r_out_bad;
    logic                      n_out_bad;

    logic [DIM_W-1:0] w_nr;
    logic [DIM_W-1:0] w_nk;
    logic [DIM_W-1:0] w_nc;
    logic             w_in_take;
    logic             w_out_free;
    logic             w_a_we;
    logic             w_b_we;
    logic             w_row_ok;
    logic             w_shift;
    logic [IW-1:0]    w_a_rd_addr_k;

    // Cell chain wiring
    logic signed [EW-1:0]    w_a_chain   [0:LIM-1];
    logic [IW-1:0]           w_k_chain   [0:LIM-1];
    t_beat_ctl               w_ctl_chain [0:LIM-1];
    logic signed [ACC_W-1:0] w_res_chain [0:LIM];
    logic [LIM-1:0]          w_done;
    t_beat_ctl               w_tail_ctl;

    // Rounding of the head sum
    logic signed [63:0]       w_wide;
    logic signed [63:0]       w_q;
    logic signed [PROD_W-1:0] w_rounded;

    // Clamp each dimension to the chain length.
    assign w_nr = (r_rows_a    > LIM_D) ? LIM_D : r_rows_a;
    assign w_nk = (r_inner_dim > LIM_D) ? LIM_D : r_inner_dim;
    assign w_nc = (r_cols_b    > LIM_D) ? LIM_D : r_cols_b;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign w_in_take   = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;

    assign w_row_ok = ({1'b0, i_row} < w_nr);
    assign w_a_we   = w_in_take && (i_mode == MODE_LOAD_A) && w_row_ok
                      && ({1'b0, i_col} < w_nk);
    assign w_b_we   = w_in_take && (i_mode == MODE_LOAD_B)
                      && ({1'b0, i_row} < w_nk) && ({1'b0, i_col} < w_nc);

    // Q8.24 sum to Q16.16: add half an LSB, floor-shift, then clamp.
    assign w_wide = 64'(w_res_chain[0]);
    assign w_q    = (w_wide + 64'sd128) >>> 8;
    always_comb begin
        if (w_q > 64'sd2147483647) begin
            w_rounded = 32'sh7fffffff;
        end else if (w_q < -64'sd2147483648) begin
            w_rounded = 32'sh80000000;
        end else begin
            w_rounded = w_q[PROD_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= RESET_D;
            r_inner_dim <= RESET_D;
            r_cols_b    <= RESET_D;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A store: write on a load transfer, read the streaming row every cycle.
    assign w_a_rd_addr_k = r_k;
    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            a_mem[{i_row[IW-1:0], i_col[IW-1:0]}] <= i_value[EW-1:0];
        end
        r_a_rd   <= a_mem[{r_row[IW-1:0], w_a_rd_addr_k}];
        r_beat_k <= r_k;
    end

    // Next state, counters, beat control and output register load.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_k         = r_k;
        n_j         = r_j;
        n_beat_ctl  = '0;
        w_shift     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_prod  = r_out_prod;
        n_out_last  = r_out_last;
        n_out_bad   = r_out_bad;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take && (i_mode == MODE_COMPUTE)) begin
                    n_row = i_row;
                    n_k   = '0;
                    if (!w_row_ok) begin
                        n_state = ST_BAD;
                    end else if (w_nc != '0) begin
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                // Stream one A element per cycle; an empty inner dimension
                // still sends one beat so that every cell clears its sum.
                n_beat_ctl.v     = 1'b1;
                n_beat_ctl.first = (r_k == '0);
                n_beat_ctl.zero  = (w_nk == '0);
                n_beat_ctl.last  = (w_nk == '0) || ((DIM_W'(r_k) + 1'b1) == w_nk);
                if (n_beat_ctl.last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WAIT: begin
                if (w_done[LIM-1]) begin
                    n_j     = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    w_shift     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = IDX_W'(r_j);
                    n_out_prod  = w_rounded;
                    n_out_last  = ((DIM_W'(r_j) + 1'b1) == w_nc);
                    n_out_bad   = 1'b0;
                    n_j         = r_j + 1'b1;
                    if (n_out_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = '0;
                    n_out_prod  = '0;
                    n_out_last  = 1'b1;
                    n_out_bad   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_j         <= '0;
            r_beat_ctl  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_j         <= n_j;
            r_beat_ctl  <= n_beat_ctl;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: hold unless the sequencer reloads it.
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_prod <= n_out_prod;
        r_out_last <= n_out_last;
        r_out_bad  <= n_out_bad;
    end

    // Cell chain: A elements advance one cell per cycle; sums shift toward
    // the head during the drain, zero entering at the tail.
    assign w_a_chain[0]     = r_a_rd;
    assign w_k_chain[0]     = r_beat_k;
    assign w_ctl_chain[0]   = r_beat_ctl;
    assign w_res_chain[LIM] = '0;

    for (genvar g = 0; g < LIM; g++) begin : g_cell
        if (g < LIM-1) begin : g_mid
            mme_cell #(
                .EW    (EW),
                .IW    (IW),
                .ACC_W (ACC_W),
                .COL   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_a     (w_a_chain[g]),
                .i_k     (w_k_chain[g]),
                .i_ctl   (w_ctl_chain[g]),
                .o_a     (w_a_chain[g+1]),
                .o_k     (w_k_chain[g+1]),
                .o_ctl   (w_ctl_chain[g+1]),
                .i_wen   (w_b_we),
                .i_wcol  (i_col[IW-1:0]),
                .i_waddr (i_row[IW-1:0]),
                .i_wdata (i_value[EW-1:0]),
                .i_shift (w_shift),
                .i_res   (w_res_chain[g+1]),
                .o_res   (w_res_chain[g]),
                .o_done  (w_done[g])
            );
        end else begin : g_tail
            mme_cell #(
                .EW    (EW),
                .IW    (IW),
                .ACC_W (ACC_W),
                .COL   (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_a     (w_a_chain[g]),
                .i_k     (w_k_chain[g]),
                .i_ctl   (w_ctl_chain[g]),
                .o_a     (),
                .o_k     (),
                .o_ctl   (w_tail_ctl),
                .i_wen   (w_b_we),
                .i_wcol  (i_col[IW-1:0]),
                .i_waddr (i_row[IW-1:0]),
                .i_wdata (i_value[EW-1:0]),
                .i_shift (w_shift),
                .i_res   (w_res_chain[g+1]),
                .o_res   (w_res_chain[g]),
                .o_done  (w_done[g])
            );
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product = r_out_prod;
    assign o_last    = r_out_last;
    assign o_bad_row = r_out_bad;

    // Cells finish in turn down the chain, so at most one reports done at a time.
    `MME_ASSERT_IMP(a_done_skewed, 1'b1, $onehot0(w_done), "two cells finished together")
    `MME_ASSERT_IMP(a_done_in_wait, w_done[LIM-1], r_state == ST_WAIT,
        "tail cell finished outside the wait phase")
    `MME_ASSERT_IMP(a_tail_beat, w_tail_ctl.v, r_state == ST_ISSUE || r_state == ST_WAIT,
        "beat in the chain tail after the row completed")
    `MME_ASSERT_IMP(a_bad_is_last, r_out_valid && r_out_bad, r_out_last,
        "bad row result not marked last")
    `MME_ASSERT_NXT(a_start_issue,
        w_in_take && i_mode == MODE_COMPUTE && w_row_ok && w_nc != '0,
        r_state == ST_ISSUE, "good compute did not start streaming")

endmodule

`default_nettype wire

// ===== verif/matrix_multiply_engine_top_test.sv =====
// Self-checking testbench of the matrix multiply engine: random loads and row computes.
`timescale 1ns / 1ps

// One product entry as the block presents it on its output channel.
typedef struct packed {
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [31:0] product;
    logic               last;
    logic               bad_row;
} product_entry_t;

// Mirror of both matrices and the dimension registers; predicts product rows.
class product_tracker;
    localparam int unsigned DIM_REACH =
        (mme_pkg::DEF_MAX_DIM < 32) ? mme_pkg::DEF_MAX_DIM : 32;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    bit signed [15:0] a_elem [1024];
    bit signed [15:0] b_elem [1024];
    bit               a_set  [1024];
    bit               b_set  [1024];
    logic [5:0]       rows_a    = 6'd32;
    logic [5:0]       inner_dim = 6'd32;
    logic [5:0]       cols_b    = 6'd32;
    product_entry_t   pending_entries [$];
    int               failures = 0;

    function int unsigned reach(input logic [5:0] d);
        return (d > DIM_REACH) ? DIM_REACH : int'(d);
    endfunction

    function void note_config(input logic [1:0] idx, input logic [5:0] data);
        case (idx)
            mme_pkg::CFG_ROWS_A:    rows_a    = data;
            mme_pkg::CFG_INNER_DIM: inner_dim = data;
            mme_pkg::CFG_COLS_B:    cols_b    = data;
            default: ;
        endcase
    endfunction

    // True when a compute of row r reads only entries written so far.
    function bit row_ready(input logic [4:0] r);
        int unsigned nr = reach(rows_a);
        int unsigned nk = reach(inner_dim);
        int unsigned nc = reach(cols_b);
        if (r >= nr || nc == 0)
            return 1'b1;
        for (int k = 0; k < nk; k++)
            if (!a_set[{r, 5'(k)}])
                return 1'b0;
        for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++)
                if (!b_set[{5'(k), 5'(j)}])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted input transfer; returns 1 unless the block ignores it.
    function bit note_item(input logic [1:0] mode, input logic [4:0] r, c,
                           input logic [15:0] v);
        int unsigned    nr = reach(rows_a);
        int unsigned    nk = reach(inner_dim);
        int unsigned    nc = reach(cols_b);
        longint         acc;
        longint         q;
        product_entry_t e;
        case (mode)
            mme_pkg::MODE_LOAD_A: begin
                if (r >= nr || c >= nk)
                    return 1'b0;
                a_elem[{r, c}] = v;
                a_set[{r, c}]  = 1'b1;
                return 1'b1;
            end
            mme_pkg::MODE_LOAD_B: begin
                if (r >= nk || c >= nc)
                    return 1'b0;
                b_elem[{r, c}] = v;
                b_set[{r, c}]  = 1'b1;
                return 1'b1;
            end
            mme_pkg::MODE_COMPUTE: begin
                e.out_row = r;
                if (r >= nr) begin
                    e.out_col = '0;
                    e.product = '0;
                    e.last    = 1'b1;
                    e.bad_row = 1'b1;
                    pending_entries.push_back(e);
                    return 1'b1;
                end
                for (int j = 0; j < nc; j++) begin
                    acc = 0;
                    for (int k = 0; k < nk; k++)
                        acc += longint'(a_elem[{r, 5'(k)}]) * longint'(b_elem[{5'(k), 5'(j)}]);
                    // Q8.24 down to Q16.16, half rounds toward plus infinity.
                    q = (acc + 128) >>> 8;
                    if (q > SAT_HI) q = SAT_HI;
                    if (q < SAT_LO) q = SAT_LO;
                    e.out_col = 5'(j);
                    e.product = 32'(q);
                    e.last    = (j == nc - 1);
                    e.bad_row = 1'b0;
                    pending_entries.push_back(e);
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function void check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_entry(input product_entry_t got);
        product_entry_t want;
        if (pending_entries.size() == 0) begin
            $error("unexpected result: row %0d col %0d product %0d",
                   got.out_row, got.out_col, got.product);
            failures++;
        end else begin
            want = pending_entries.pop_front();
            check_field("out_row", want.out_row, got.out_row);
            check_field("out_col", want.out_col, got.out_col);
            check_field("product", want.product, got.product);
            check_field("last",    want.last,    got.last);
            check_field("bad_row", want.bad_row, got.bad_row);
        end
    endfunction
endclass

module matrix_multiply_engine_top_test;
    import mme_pkg::*;

    localparam int         RESET_CYCLES = 2;
    localparam int         DRAIN_CYCLES = 160;   // chain fill plus a full row of output
    localparam int         STALL_LIMIT  = 4000;  // cycles without any transfer
    localparam int         ITEM_TARGET  = 400;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               in_mode  = '0;
    logic [IDX_W-1:0]         in_row   = '0;
    logic [IDX_W-1:0]         in_col   = '0;
    logic signed [FIELD_ELEM_W-1:0] in_value = '0;

    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] out_product;
    logic                     out_last;
    logic                     out_bad_row;

    product_tracker tracker = new;
    int             work_done = 0;   // transfers the block acts on
    bit             in_steady = 1'b0;

    matrix_multiply_engine_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_mode      (in_mode),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_value     (in_value),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_product   (out_product),
        .o_last      (out_last),
        .o_bad_row   (out_bad_row)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Element values lean on the two full-scale extremes now and then.
    function automatic logic [15:0] draw_element();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one input item after a random gap and hold it until the transfer.
    task automatic send_item(input logic [1:0] mode, input logic [4:0] r, c,
                             input logic [15:0] v);
        int gap;
        // Toggle now and then into a stretch with no gaps at all.
        if ($urandom_range(0, 15) == 0)
            in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_row   <= r;
        in_col   <= c;
        in_value <= v;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (tracker.note_item(mode, r, c, v))
            work_done++;
    endtask

    // Drop valid, wait for every expected entry, then let any silent work finish.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (tracker.pending_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Hold cfg_valid high across back-to-back register transfers.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        tracker.note_config(idx, data);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, inner, cols);
        wait_quiet();
        write_reg(CFG_UNUSED, 6'($urandom));   // unmapped index, must be dropped
        write_reg(CFG_ROWS_A, rows);
        write_reg(CFG_INNER_DIM, inner);
        write_reg(CFG_COLS_B, cols);
        cfg_valid <= 1'b0;
    endtask

    // Occasionally slip in a stray item: unused mode, random load or legal compute.
    task automatic maybe_noise();
        logic [4:0] r;
        if ($urandom_range(0, 9) == 0) begin
            r = 5'($urandom);
            case ($urandom_range(0, 3))
                0: send_item(MODE_UNUSED, r, 5'($urandom), 16'($urandom));
                1: send_item(MODE_LOAD_A, r, 5'($urandom), draw_element());
                2: send_item(MODE_LOAD_B, r, 5'($urandom), draw_element());
                default: begin
                    if (tracker.row_ready(r))
                        send_item(MODE_COMPUTE, r, 5'($urandom), 16'($urandom));
                    else
                        send_item(MODE_UNUSED, r, 5'($urandom), 16'($urandom));
                end
            endcase
        end
    endtask

    // Corners of the fields, every mode and the special dimension settings.
    task automatic run_directed();
        set_dims(6'd2, 6'd2, 6'd2);
        send_item(MODE_LOAD_A, 5'd0, 5'd0, 16'h7FFF);
        send_item(MODE_LOAD_A, 5'd0, 5'd1, 16'h8000);
        send_item(MODE_LOAD_A, 5'd1, 5'd0, 16'h0000);
        send_item(MODE_LOAD_A, 5'd1, 5'd1, 16'hFFFF);
        send_item(MODE_LOAD_B, 5'd0, 5'd0, 16'h8000);
        send_item(MODE_LOAD_B, 5'd0, 5'd1, 16'h7FFF);
        send_item(MODE_LOAD_B, 5'd1, 5'd0, 16'h8000);
        send_item(MODE_LOAD_B, 5'd1, 5'd1, 16'h0001);
        // Loads outside the configured shape: drop them.
        send_item(MODE_LOAD_A, 5'd2, 5'd0, 16'h1234);
        send_item(MODE_LOAD_A, 5'd31, 5'd31, 16'h5555);
        send_item(MODE_LOAD_B, 5'd0, 5'd2, 16'h4321);
        send_item(MODE_LOAD_B, 5'd2, 5'd0, 16'hAAAA);
        send_item(MODE_UNUSED, 5'd31, 5'd31, 16'hAAAA);
        send_item(MODE_COMPUTE, 5'd0, 5'd31, 16'hFFFF);
        send_item(MODE_COMPUTE, 5'd1, 5'd0, 16'h0000);
        // Rows past rows_a give a single flagged entry.
        send_item(MODE_COMPUTE, 5'd2, 5'd0, 16'h0000);
        send_item(MODE_COMPUTE, 5'd31, 5'd31, 16'h5555);
        send_item(MODE_LOAD_A, 5'd0, 5'd0, 16'h8000);
        send_item(MODE_COMPUTE, 5'd0, 5'd0, 16'h0000);
        // No rows in use: every compute is a bad row.
        set_dims(6'd0, 6'd2, 6'd2);
        send_item(MODE_COMPUTE, 5'd0, 5'd0, 16'h0000);
        // Empty inner dimension: loads of A drop, products are zero.
        set_dims(6'd2, 6'd0, 6'd2);
        send_item(MODE_LOAD_A, 5'd0, 5'd0, 16'h7FFF);
        send_item(MODE_COMPUTE, 5'd1, 5'd0, 16'h0000);
        // No columns: a good row yields nothing.
        set_dims(6'd2, 6'd2, 6'd0);
        send_item(MODE_COMPUTE, 5'd0, 5'd0, 16'h0000);
        // Register beyond the index reach acts as 32 rows.
        set_dims(6'd63, 6'd2, 6'd2);
        send_item(MODE_LOAD_A, 5'd31, 5'd0, 16'h7FFF);
        send_item(MODE_LOAD_A, 5'd31, 5'd1, 16'h8000);
        send_item(MODE_COMPUTE, 5'd31, 5'd0, 16'h0000);
    endtask

    // One setting of the dimensions: fill B, then load and compute a few rows of A.
    task automatic run_phase();
        logic [DIM_W-1:0] rows, inner, cols;
        int unsigned      nr, nk, nc, r;
        // Keep the B matrix small so a phase stays short.
        case ($urandom_range(0, 7))
            0: begin
                rows  = 6'($urandom_range(32, 63));
                inner = 6'd1;
                cols  = 6'($urandom_range(32, 63));
            end
            1: begin
                rows  = 6'($urandom_range(1, 6));
                inner = 6'($urandom_range(32, 63));
                cols  = 6'd1;
            end
            2: begin
                rows  = 6'($urandom_range(1, 6));
                inner = 6'($urandom_range(1, 6));
                cols  = 6'($urandom_range(1, 6));
                case ($urandom_range(0, 2))
                    0:       rows  = 6'd0;
                    1:       inner = 6'd0;
                    default: cols  = 6'd0;
                endcase
            end
            default: begin
                rows  = 6'($urandom_range(1, 6));
                inner = 6'($urandom_range(1, 6));
                cols  = 6'($urandom_range(1, 6));
            end
        endcase
        set_dims(rows, inner, cols);
        nr = tracker.reach(rows);
        nk = tracker.reach(inner);
        nc = tracker.reach(cols);

        for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++) begin
                maybe_noise();
                send_item(MODE_LOAD_B, 5'(k), 5'(j), draw_element());
            end

        repeat ($urandom_range(1, 4)) begin
            r = (nr == 0) ? $urandom_range(0, 31) : $urandom_range(0, nr - 1);
            // Reload the row when it is incomplete, and half the time anyway.
            if (!tracker.row_ready(5'(r)) || $urandom_range(0, 1) == 1)
                for (int k = 0; k < nk; k++) begin
                    maybe_noise();
                    send_item(MODE_LOAD_A, 5'(r), 5'(k), draw_element());
                end
            send_item(MODE_COMPUTE, 5'(r), 5'($urandom), 16'($urandom));
            if (nr < 32 && $urandom_range(0, 3) == 0)
                send_item(MODE_COMPUTE, 5'($urandom_range(31, nr)), 5'($urandom),
                          16'($urandom));
        end
    endtask

    // Sink: stall a random number of cycles per entry, then take and check it.
    initial begin : result_sink
        product_entry_t got;
        int             stall;
        bit             steady;
        steady = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            got.out_row = out_row;
            got.out_col = out_col;
            got.product = out_product;
            got.last    = out_last;
            got.bad_row = out_bad_row;
            tracker.check_entry(got);
        end
    end

    // Watchdog: end the run once no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (work_done < ITEM_TARGET)
            run_phase();
        wait_quiet();
        if (tracker.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
